>>> rtl/rpn_stack_calculator_defines.svh
// rpn_stack_calculator_defines.svh: assertion macros for the rpn stack calculator
// expects a clock named clk and an active-low reset named arst_n in the using scope
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RPN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define RPN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rpn_pkg.sv
// rpn_pkg: types, codes and the saturation helper for the rpn stack calculator
// no dependencies; used by rpn_div and rpn_stack_calculator
`timescale 1ns / 1ps

package rpn_pkg;

	// stack size default
	localparam int RPN_STACK_DEPTH = 16;

	// command codes
	localparam logic [2:0] MODE_PUSH = 3'd0;
	localparam logic [2:0] MODE_ADD  = 3'd1;
	localparam logic [2:0] MODE_SUB  = 3'd2;
	localparam logic [2:0] MODE_MUL  = 3'd3;
	localparam logic [2:0] MODE_DIV  = 3'd4;
	localparam logic [2:0] MODE_SHOW = 3'd5;

	// status codes
	localparam logic [2:0] STAT_OK     = 3'd0;
	localparam logic [2:0] STAT_FULL   = 3'd1;
	localparam logic [2:0] STAT_FEW    = 3'd2;
	localparam logic [2:0] STAT_DIVZ   = 3'd3;
	localparam logic [2:0] STAT_SAT    = 3'd4;

	// divider sizing: dividend is |a| shifted up by the 16 fraction bits
	localparam int DIV_DVD_W = 48;
	localparam int DIV_DVS_W = 32;
	localparam int DIV_STEPS = DIV_DVD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
	localparam int WIDE_W    = DIV_DVD_W + 1;

	// saturation bounds of q16.16
	localparam logic signed [WIDE_W-1:0] SAT_MAX = 49'sd2147483647;
	localparam logic signed [WIDE_W-1:0] SAT_MIN = -49'sd2147483648;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] operand_value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic [4:0]         stack_depth;
		logic [2:0]         status;
	} res_t;

	typedef struct packed {
		logic                 start;
		logic                 neg;
		logic [DIV_DVD_W-1:0] dividend;
		logic [DIV_DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [WIDE_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} sat_t;

	// clamp a wide signed result into q16.16
	function automatic sat_t saturate(input logic signed [WIDE_W-1:0] v);
		sat_t r;
		r.val = v[31:0];
		r.sat = 1'b0;
		if (v > SAT_MAX) begin
			r.val = 32'h7FFF_FFFF;
			r.sat = 1'b1;
		end else if (v < SAT_MIN) begin
			r.val = 32'h8000_0000;
			r.sat = 1'b1;
		end
		return r;
	endfunction

endpackage

>>> rtl/rpn_ram.sv
// rpn_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/rpn_div.sv
// rpn_div: restoring divider, one quotient bit per cycle, sign applied at the end
// depends on rpn_pkg
`timescale 1ns / 1ps

module rpn_div
	import rpn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic                 neg_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DVS_W-1:0] dvs_q;
	logic [DIV_DVS_W-1:0] rem_q;

	logic [DIV_DVS_W:0]   rem_sh;
	logic [DIV_DVS_W:0]   rem_sub;
	logic                 ge;
	logic [WIDE_W-1:0]    mag;

	// one trial subtraction
	always_comb begin
		rem_sh  = {rem_q, dvd_q[DIV_DVD_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + DIV_CNT_W'(1);
				if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.neg;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DIV_DVS_W-1:0] : rem_sh[DIV_DVS_W-1:0];
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], ge};
		end
	end

	// signed quotient, truncated toward zero
	always_comb begin
		mag      = {1'b0, dvd_q};
		rsp.done = done_q;
		rsp.quot = neg_q ? -$signed(mag) : $signed(mag);
	end

endmodule

>>> rtl/rpn_stack_calculator.sv
// rpn_stack_calculator: top level, stack in a ram with the top entry cached in a register
// depends on rpn_pkg, rpn_ram, rpn_div and rpn_stack_calculator_defines.svh
//
// Usage: drive cmd and raise start; the item is taken at a clock edge where start is
// high and busy is low. Every item gives exactly one result: done is high for one
// cycle and result holds top value, depth and status in that cycle. The receiver
// cannot stall; results must be taken when done is high.
// Steps from accept to done:
//   push, show, ignored codes and rejected operations: done follows in the next cycle, busy stays low
//   add and subtract: ram read with compute and clamp, then write back
//   multiply: ram read into a 32x32 product register, shift and clamp, write back
//   divide: ram read, the 48-step one-bit-per-cycle restoring divider, write back
// The next item can be taken as soon as busy is low, the same cycle done shows.
// The entry below the top is read from the single ram read port, the top lives in a register.
// Reset empties the stack (depth zero) and clears busy and done; ram contents are
// not cleared, entries above the depth are never used.
`timescale 1ns / 1ps
`include "rpn_stack_calculator_defines.svh"

module rpn_stack_calculator
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = RPN_STACK_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t result
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_WB   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          done_q, done_d;
	res_t          result_q, result_d;
	logic [31:0]   top_q, top_d;
	logic [2:0]    mode_q, mode_d;
	logic [31:0]   res_q, res_d;
	logic          sat_q, sat_d;
	logic signed [63:0] prod_q, prod_d;

	logic          accept;
	logic [CW-1:0] cnt_m2;
	logic [CW-1:0] cnt_p1;
	logic [CW-1:0] cnt_m1;
	logic [31:0]   top_shown;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic [31:0]   rdata;
	logic signed [WIDE_W-1:0] wide;
	sat_t          clamp;
	div_req_t      div_req;
	div_rsp_t      div_rsp;

	// depth field is the count masked to five bits
	function automatic logic [4:0] depth5(input logic [CW-1:0] c);
		logic [CW+4:0] w;
		w = {5'd0, c};
		return w[4:0];
	endfunction

	rpn_ram #(
		.WIDTH(32),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(cnt_m2[AW-1:0]),
		.rdata(rdata)
	);

	rpn_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign accept    = start && !busy;
	assign cnt_m2    = count_q - CW'(2);
	assign cnt_m1    = count_q - CW'(1);
	assign cnt_p1    = count_q + CW'(1);
	assign top_shown = (count_q != '0) ? top_q : '0;
	assign clamp     = saturate(wide);

	// divider operands from the entry below the top and the cached top
	always_comb begin
		logic [31:0] abs_a;
		logic [31:0] abs_b;
		abs_a            = rdata[31] ? -rdata : rdata;
		abs_b            = top_q[31] ? -top_q : top_q;
		div_req.start    = (state_q == ST_READ) && (mode_q == MODE_DIV);
		div_req.neg      = rdata[31] ^ top_q[31];
		div_req.dividend = {abs_a, 16'd0};
		div_req.divisor  = abs_b;
	end

	// wide result ahead of the clamp, picked by state and operation
	always_comb begin
		wide = '0;
		unique case (state_q)
			ST_READ: begin
				case (mode_q)
					MODE_ADD: begin
						wide = WIDE_W'($signed(rdata)) + WIDE_W'($signed(top_q));
					end
					MODE_SUB: begin
						wide = WIDE_W'($signed(rdata)) - WIDE_W'($signed(top_q));
						wide = wide[WIDE_W-1] ? -wide : wide;
					end
					default: begin
					end
				endcase
			end
			// arithmetic shift by 16 rounds toward minus infinity
			ST_MUL: begin
				wide = WIDE_W'($signed(prod_q[63:16]));
			end
			ST_DIV: begin
				wide = div_rsp.quot;
			end
			default: begin
			end
		endcase
	end

	// sequencer and next-state logic
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		done_d    = 1'b0;
		result_d  = result_q;
		top_d     = top_q;
		mode_d    = mode_q;
		res_d     = res_q;
		sat_d     = sat_q;
		prod_d    = prod_q;
		mem_we    = 1'b0;
		mem_waddr = cnt_m2[AW-1:0];
		mem_wdata = res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_d   = cmd.mode;
					done_d   = 1'b1;
					result_d = '{top_value: top_shown, stack_depth: depth5(count_q),
						status: STAT_OK};
					unique case (cmd.mode) inside
						MODE_PUSH: begin
							if (count_q == CW'(STACK_DEPTH)) begin
								result_d.status = STAT_FULL;
							end else begin
								mem_we               = 1'b1;
								mem_waddr            = count_q[AW-1:0];
								mem_wdata            = cmd.operand_value;
								top_d                = cmd.operand_value;
								count_d              = cnt_p1;
								result_d.top_value   = cmd.operand_value;
								result_d.stack_depth = depth5(cnt_p1);
							end
						end
						MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
							if (count_q < CW'(2)) begin
								result_d.status = STAT_FEW;
							end else if (cmd.mode == MODE_DIV && top_q == '0) begin
								result_d.status = STAT_DIVZ;
							end else begin
								done_d  = 1'b0;
								state_d = ST_READ;
							end
						end
						MODE_SHOW: begin
							count_d              = '0;
							result_d.stack_depth = '0;
							if (count_q == '0) begin
								result_d.status = STAT_FEW;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				// rdata holds the entry below the top
				case (mode_q)
					MODE_ADD: begin
						res_d   = clamp.val;
						sat_d   = clamp.sat;
						state_d = ST_WB;
					end
					MODE_SUB: begin
						res_d   = clamp.val;
						sat_d   = clamp.sat;
						state_d = ST_WB;
					end
					MODE_MUL: begin
						prod_d  = $signed(rdata) * $signed(top_q);
						state_d = ST_MUL;
					end
					default: begin
						state_d = ST_DIV;
					end
				endcase
			end
			ST_MUL: begin
				res_d   = clamp.val;
				sat_d   = clamp.sat;
				state_d = ST_WB;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					res_d   = clamp.val;
					sat_d   = clamp.sat;
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				// result replaces the two operands
				mem_we   = 1'b1;
				top_d    = res_q;
				count_d  = cnt_m1;
				done_d   = 1'b1;
				result_d = '{top_value: res_q, stack_depth: depth5(cnt_m1),
					status: sat_q ? STAT_SAT : STAT_OK};
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		result_q <= result_d;
		top_q    <= top_d;
		mode_q   <= mode_d;
		res_q    <= res_d;
		sat_q    <= sat_d;
		prod_q   <= prod_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// checks
	`RPN_ASSERT_IMP(a_depth_bound, 1'b1, count_q <= CW'(STACK_DEPTH), "stack count above depth")
	`RPN_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
	`RPN_ASSERT_IMP(a_div_in_state, div_rsp.done, state_q == ST_DIV, "divider done outside divide")
	`RPN_ASSERT_NXT(a_push_count,
		accept && cmd.mode == MODE_PUSH && count_q != CW'(STACK_DEPTH),
		count_q == $past(count_q) + CW'(1), "push did not grow the stack")

endmodule
